// ----- hw/rtl/g2r_pkg.sv -----
// ----------------------------------------------------------------------------
// g2r_pkg: shared types and constants for the glob-to-regex converter
// Character codes, the burst record passed from front to back end, and the
// escape test for regex metacharacters.
// ----------------------------------------------------------------------------
`default_nettype none

package g2r_pkg;

	// Most result beats a single input beat can cause
	localparam int unsigned MAX_BURST = 5;
	localparam int unsigned CNT_W = $clog2(MAX_BURST + 1);
	localparam int unsigned IDX_W = $clog2(MAX_BURST);

	// Character codes
	localparam logic [7:0] CH_STAR   = 8'h2A; // '*'
	localparam logic [7:0] CH_QUEST  = 8'h3F; // '?'
	localparam logic [7:0] CH_CARET  = 8'h5E; // '^'
	localparam logic [7:0] CH_DOLLAR = 8'h24; // '$'
	localparam logic [7:0] CH_DOT    = 8'h2E; // '.'
	localparam logic [7:0] CH_BSLASH = 8'h5C; // '\'
	localparam logic [7:0] CH_PIPE   = 8'h7C; // '|'
	localparam logic [7:0] CH_LBRACE = 8'h7B; // '{'
	localparam logic [7:0] CH_RBRACE = 8'h7D; // '}'
	localparam logic [7:0] CH_LPAREN = 8'h28; // '('
	localparam logic [7:0] CH_RPAREN = 8'h29; // ')'
	localparam logic [7:0] CH_LBRACK = 8'h5B; // '['
	localparam logic [7:0] CH_RBRACK = 8'h5D; // ']'
	localparam logic [7:0] CH_PLUS   = 8'h2B; // '+'
	localparam logic [7:0] CH_NUL    = 8'h00;

	// One input beat's worth of output bytes
	typedef struct packed {
		logic [MAX_BURST-1:0][7:0] chr;    // bytes in emission order, entry 0 first
		logic [CNT_W-1:0]          cnt;    // number of result beats, 1..MAX_BURST
		logic                      marker; // bare end marker, no valid byte
		logic                      last;   // final beat of the burst closes the pattern
	} burst_t;

	// Regex metacharacters that need a backslash
	function automatic logic needs_escape(input logic [7:0] c);
		logic r;
		case (c)
			CH_CARET, CH_DOLLAR, CH_PIPE, CH_LBRACE, CH_RBRACE,
			CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_BSLASH,
			CH_PLUS, CH_DOT: r = 1'b1;
			default:         r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/glob_to_regex_converter_top.sv -----
// ----------------------------------------------------------------------------
// glob_to_regex_converter_top: glob pattern to anchored regex translator
// Usage:
//   Input stream s_axis_*: one pattern byte per beat in tdata, tlast marks the
//   final byte, tuser flags an empty pattern (emits "^$", tdata ignored).
//   Output stream m_axis_*: one regex byte per beat in tdata, tuser set when
//   the byte is real (clear on a bare end marker), tlast on the final beat of
//   the pattern.
//   Throughput: one input beat per cycle while the burst queue has room; an
//   input beat expands to 0..5 output beats, sent one per cycle while
//   m_axis_tready is high, so the output side sets the sustained rate.
//   Path: the first result beat of an input beat is written into the burst
//   queue, then loaded into the output register, and is valid from there.
//   The front end classifies bytes and pushes bursts into a QUEUE_DEPTH-entry
//   queue; the back end serializes them through an output register.
//   Reset: all patterns in flight are dropped, state returns to pattern start.
//   Stall: when m_axis_tready is low, the output holds; the queue fills and
//   s_axis_tready drops once QUEUE_DEPTH bursts are waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_to_regex_converter_top
	import g2r_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] pattern_char
	input  wire logic       s_axis_tlast,
	input  wire logic [0:0] s_axis_tuser,  // [0] pattern_empty
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] out_char
	output logic            m_axis_tlast,
	output logic [0:0]      m_axis_tuser   // [0] char_valid
);

	logic   q_full;
	logic   q_nonempty;
	logic   push;
	logic   pop;
	burst_t push_burst;
	burst_t q_head;

	g2r_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_char    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.in_empty   (s_axis_tuser[0]),
		.q_full     (q_full),
		.in_ready   (s_axis_tready),
		.push       (push),
		.push_burst (push_burst)
	);

	g2r_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_burst (push_burst),
		.pop        (pop),
		.full       (q_full),
		.nonempty   (q_nonempty),
		.head       (q_head)
	);

	g2r_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_nonempty     (q_nonempty),
		.q_head         (q_head),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_char       (m_axis_tdata),
		.out_char_valid (m_axis_tuser[0]),
		.out_last       (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/g2r_front.sv -----
// ----------------------------------------------------------------------------
// g2r_front: pattern classifier
// Accepts pattern bytes, tracks start / literal / pending-wildcard state and
// turns each byte into a burst of output bytes for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module g2r_front
	import g2r_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_char,
	input  wire logic       in_last,
	input  wire logic       in_empty,
	input  wire logic       q_full,
	output logic            in_ready,
	output logic            push,
	output burst_t          push_burst
);

	logic at_start_q;
	logic seen_literal_q;
	logic wildcard_pending_q;
	logic accept;
	logic is_star;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_star  = (in_char == CH_STAR);

	// Build the burst for the current byte
	always_comb begin
		logic [MAX_BURST-1:0][7:0] chr;
		logic [CNT_W-1:0]          n;
		chr = '0;
		n   = '0;
		push_burst = '0;
		if (in_empty) begin
			chr[0] = CH_CARET;
			chr[1] = CH_DOLLAR;
			n      = CNT_W'(2);
		end else begin
			if (at_start_q && !is_star) begin
				chr[IDX_W'(n)] = CH_CARET;
				n = n + 1'b1;
			end
			if (!is_star) begin
				if (wildcard_pending_q) begin
					chr[IDX_W'(n)] = CH_DOT;
					n = n + 1'b1;
					chr[IDX_W'(n)] = CH_STAR;
					n = n + 1'b1;
				end
				if (in_char == CH_QUEST) begin
					chr[IDX_W'(n)] = CH_DOT;
					n = n + 1'b1;
				end else if (needs_escape(in_char)) begin
					chr[IDX_W'(n)] = CH_BSLASH;
					n = n + 1'b1;
					chr[IDX_W'(n)] = in_char;
					n = n + 1'b1;
				end else begin
					chr[IDX_W'(n)] = in_char;
					n = n + 1'b1;
				end
				if (in_last) begin
					chr[IDX_W'(n)] = CH_DOLLAR;
					n = n + 1'b1;
				end
			end
		end
		// silent last byte: bare end marker
		push_burst.marker = 1'b0;
		if (in_last && !in_empty && n == '0) begin
			chr[0] = CH_NUL;
			n      = CNT_W'(1);
			push_burst.marker = 1'b1;
		end
		push_burst.chr  = chr;
		push_burst.cnt  = n;
		push_burst.last = in_last || in_empty;
	end

	assign push = accept && (push_burst.cnt != '0);

	// Pattern state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q         <= 1'b1;
			seen_literal_q     <= 1'b0;
			wildcard_pending_q <= 1'b0;
		end else if (accept) begin
			if (in_empty || in_last) begin
				at_start_q         <= 1'b1;
				seen_literal_q     <= 1'b0;
				wildcard_pending_q <= 1'b0;
			end else begin
				at_start_q <= 1'b0;
				if (is_star) begin
					wildcard_pending_q <= wildcard_pending_q || seen_literal_q;
				end else begin
					wildcard_pending_q <= 1'b0;
					seen_literal_q     <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/g2r_queue.sv -----
// ----------------------------------------------------------------------------
// g2r_queue: burst queue
// Small FIFO of bursts between the front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module g2r_queue
	import g2r_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  burst_t       push_burst,
	input  wire logic    pop,
	output logic         full,
	output logic         nonempty,
	output burst_t       head
);

	localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

	burst_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [COUNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == COUNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_burst;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/g2r_back.sv -----
// ----------------------------------------------------------------------------
// g2r_back: burst serializer
// Takes bursts from the queue and sends their bytes one beat per cycle while
// out_ready does not stall the output, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module g2r_back
	import g2r_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_nonempty,
	input  burst_t          q_head,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            out_char_valid,
	output logic            out_last
);

	burst_t           cur_q;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	logic [7:0]       char_q;
	logic             cvalid_q;
	logic             last_q;

	logic             load;
	logic             have;
	burst_t           src;
	logic [IDX_W-1:0] idx;
	logic             final_beat;

	// Pick the next byte: continue current burst or start the queue head
	assign load       = !valid_q || out_ready;
	assign src        = busy_q ? cur_q : q_head;
	assign idx        = busy_q ? idx_q : '0;
	assign have       = busy_q || q_nonempty;
	assign pop        = load && !busy_q && q_nonempty;
	assign final_beat = (CNT_W'(idx) + 1'b1 == src.cnt);

	// Burst walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load && have) begin
			busy_q <= !final_beat;
			idx_q  <= idx + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= have;
		end
	end

	always_ff @(posedge clk) begin
		if (load && have) begin
			char_q   <= src.chr[idx];
			cvalid_q <= !src.marker;
			last_q   <= src.last && final_beat;
		end
	end

	assign out_valid      = valid_q;
	assign out_char       = char_q;
	assign out_char_valid = cvalid_q;
	assign out_last       = last_q;

endmodule

`default_nettype wire
